### hdl/stt_pkg.sv
// Shared types and constants for the source text tokenizer.
package stt_pkg;

    // Token kinds carried in the result word
    typedef enum logic [2:0] {
        KIND_IDENT   = 3'd0,
        KIND_KEYWORD = 3'd1,
        KIND_NUMBER  = 3'd2,
        KIND_STRING  = 3'd3,
        KIND_OPER    = 3'd4,
        KIND_UNKNOWN = 3'd5,
        KIND_EOF     = 3'd6
    } kind_t;

    // Record types
    localparam logic REC_VALUE = 1'b0;
    localparam logic REC_END   = 1'b1;

    // Output field widths
    localparam int OUT_LINE_W = 24;
    localparam int OUT_COL_W  = 16;
    localparam int OUT_LEN_W  = 16;

    // Special characters
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    // Keyword table: each word stored reversed, first character in the low byte
    localparam int KW_COUNT = 5;
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'("cnuf"), 64'("ssalc"), 64'("tcurts"), 64'("bolg"), 64'("edulcni")
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd4, 3'd5, 3'd6, 3'd4, 3'd7};

    // One result word
    typedef struct packed {
        logic                  rtype;
        kind_t                 kind;
        logic [7:0]            vchar;
        logic [OUT_LINE_W-1:0] line;
        logic [OUT_COL_W-1:0]  col;
        logic [OUT_LEN_W-1:0]  len;
    } rec_t;

    // All result words caused by one input word
    localparam int MAX_RECS = 4;
    localparam int IDX_W    = 2;

    typedef struct packed {
        rec_t [MAX_RECS-1:0] recs;
        logic [IDX_W-1:0]    last_idx;
    } bundle_t;

    // Queue write side
    typedef struct packed {
        logic    push;
        bundle_t data;
    } qwr_t;

    // Queue read side
    typedef struct packed {
        logic    empty;
        bundle_t head;
    } qrd_t;

    localparam int QDEPTH = 4;

endpackage

### hdl/stt_front.sv
// Scanner front end: classifies each byte and builds its bundle of result words.
module stt_front #(
    parameter int LINE_BITS   = 24,
    parameter int COLUMN_BITS = 16,
    parameter int LENGTH_BITS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    in_char,
    input  logic          has_char,
    input  logic          end_of_source,
    input  logic          q_full,
    output stt_pkg::qwr_t qwr
);
    import stt_pkg::*;

    typedef enum logic [7:0] {
        M_IDLE     = 8'b0000_0001,
        M_QMARK    = 8'b0000_0010,
        M_LINECMT  = 8'b0000_0100,
        M_BLOCKCMT = 8'b0000_1000,
        M_WORD     = 8'b0001_0000,
        M_NUMBER   = 8'b0010_0000,
        M_STRING   = 8'b0100_0000,
        M_OPER     = 8'b1000_0000
    } mode_t;

    mode_t                   mode_reg, mode_next;
    logic [LINE_BITS-1:0]    line_reg, line_next;
    logic [COLUMN_BITS-1:0]  col_reg, col_next;
    logic [LENGTH_BITS-1:0]  vlen_reg, vlen_next;
    logic [KW_COUNT-1:0]     cand_reg, cand_next;
    logic                    slash_reg, slash_next;

    logic                    accept;
    logic [2:0]              n;
    rec_t [MAX_RECS-1:0]     recs;
    logic                    go_idle;
    kind_t                   ek;

    // Character classes
    function automatic logic is_space(logic [7:0] c);
        return (c inside {[8'd9:8'd13], 8'd32});
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c inside {[8'd65:8'd90], [8'd97:8'd122]});
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c inside {[8'd48:8'd57]});
    endfunction

    function automatic logic is_punct(logic [7:0] c);
        return (c inside {[8'd33:8'd47], [8'd58:8'd64], [8'd91:8'd96], [8'd123:8'd126]});
    endfunction

    // Position update for one consumed byte
    function automatic logic [LINE_BITS-1:0] line_adv(logic [LINE_BITS-1:0] ln,
                                                      logic [7:0] c);
        if (c == CH_NL && ln != '1)
            return ln + LINE_BITS'(1);
        return ln;
    endfunction

    function automatic logic [COLUMN_BITS-1:0] col_adv(logic [COLUMN_BITS-1:0] cl,
                                                       logic [7:0] c);
        if (c == CH_NL)
            return COLUMN_BITS'(1);
        if (cl != '1)
            return cl + COLUMN_BITS'(1);
        return cl;
    endfunction

    // Drop keyword candidates that do not match this byte
    function automatic logic [KW_COUNT-1:0] cand_upd(logic [KW_COUNT-1:0] cd,
                                                     logic [LENGTH_BITS-1:0] ln,
                                                     logic [7:0] c);
        logic [KW_COUNT-1:0] r;
        r = cd;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (ln >= LENGTH_BITS'(KW_LEN[k]) || KW_TEXT[k][8*ln[2:0] +: 8] != c)
                r[k] = 1'b0;
        end
        return r;
    endfunction

    // Word becomes a keyword when a surviving candidate has exactly its length
    function automatic kind_t word_kind(logic [KW_COUNT-1:0] cd,
                                        logic [LENGTH_BITS-1:0] ln);
        kind_t r;
        r = KIND_IDENT;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (cd[k] && ln == LENGTH_BITS'(KW_LEN[k]))
                r = KIND_KEYWORD;
        end
        return r;
    endfunction

    function automatic rec_t val_rec(kind_t k, logic [7:0] c);
        rec_t r;
        r       = '0;
        r.rtype = REC_VALUE;
        r.kind  = k;
        r.vchar = c;
        return r;
    endfunction

    // End record: counters are zero-extended or cut to the output widths
    function automatic rec_t end_rec(kind_t k, logic [LINE_BITS-1:0] ln,
                                     logic [COLUMN_BITS-1:0] cl,
                                     logic [LENGTH_BITS-1:0] len);
        rec_t                              r;
        logic [LINE_BITS+OUT_LINE_W-1:0]   ln_x;
        logic [COLUMN_BITS+OUT_COL_W-1:0]  cl_x;
        logic [LENGTH_BITS+OUT_LEN_W-1:0]  len_x;
        ln_x    = {{OUT_LINE_W{1'b0}}, ln};
        cl_x    = {{OUT_COL_W{1'b0}}, cl};
        len_x   = {{OUT_LEN_W{1'b0}}, len};
        r       = '0;
        r.rtype = REC_END;
        r.kind  = k;
        r.line  = ln_x[OUT_LINE_W-1:0];
        r.col   = cl_x[OUT_COL_W-1:0];
        r.len   = len_x[OUT_LEN_W-1:0];
        return r;
    endfunction

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // Scan one input word
    always_comb begin
        mode_next  = mode_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        vlen_next  = vlen_reg;
        cand_next  = cand_reg;
        slash_next = slash_reg;
        n          = 3'd0;
        recs       = '0;
        go_idle    = 1'b0;
        ek         = KIND_IDENT;

        if (has_char) begin
            case (mode_reg)
                M_QMARK: begin
                    line_next = line_adv(line_next, in_char);
                    col_next  = col_adv(col_next, in_char);
                    if (in_char == CH_SLASH) begin
                        mode_next  = M_BLOCKCMT;
                        slash_next = 1'b0;
                    end else if (in_char == CH_NL) begin
                        mode_next = M_IDLE;
                    end else begin
                        mode_next = M_LINECMT;
                    end
                end
                M_LINECMT: begin
                    line_next = line_adv(line_next, in_char);
                    col_next  = col_adv(col_next, in_char);
                    if (in_char == CH_NL)
                        mode_next = M_IDLE;
                end
                M_BLOCKCMT: begin
                    line_next = line_adv(line_next, in_char);
                    col_next  = col_adv(col_next, in_char);
                    if (slash_reg && in_char == CH_QMARK) begin
                        mode_next  = M_IDLE;
                        slash_next = 1'b0;
                    end else begin
                        slash_next = (in_char == CH_SLASH);
                    end
                end
                M_WORD: begin
                    if (is_alpha(in_char) || is_digit(in_char) || in_char == CH_UNDER) begin
                        cand_next = cand_upd(cand_next, vlen_next, in_char);
                        recs[n[IDX_W-1:0]] = val_rec(KIND_IDENT, in_char);
                        n = n + 3'd1;
                        if (vlen_next != '1)
                            vlen_next = vlen_next + LENGTH_BITS'(1);
                        line_next = line_adv(line_next, in_char);
                        col_next  = col_adv(col_next, in_char);
                    end else begin
                        ek = word_kind(cand_next, vlen_next);
                        recs[n[IDX_W-1:0]] = end_rec(ek, line_next, col_next, vlen_next);
                        n = n + 3'd1;
                        mode_next = M_IDLE;
                        go_idle   = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (is_digit(in_char)) begin
                        cand_next = cand_upd(cand_next, vlen_next, in_char);
                        recs[n[IDX_W-1:0]] = val_rec(KIND_NUMBER, in_char);
                        n = n + 3'd1;
                        if (vlen_next != '1)
                            vlen_next = vlen_next + LENGTH_BITS'(1);
                        line_next = line_adv(line_next, in_char);
                        col_next  = col_adv(col_next, in_char);
                    end else begin
                        recs[n[IDX_W-1:0]] = end_rec(KIND_NUMBER, line_next, col_next,
                                                     vlen_next);
                        n = n + 3'd1;
                        mode_next = M_IDLE;
                        go_idle   = 1'b1;
                    end
                end
                M_STRING: begin
                    line_next = line_adv(line_next, in_char);
                    col_next  = col_adv(col_next, in_char);
                    if (in_char == CH_QUOTE) begin
                        recs[n[IDX_W-1:0]] = end_rec(KIND_STRING, line_next, col_next,
                                                     vlen_next);
                        n = n + 3'd1;
                        mode_next = M_IDLE;
                    end else begin
                        cand_next = cand_upd(cand_next, vlen_next, in_char);
                        recs[n[IDX_W-1:0]] = val_rec(KIND_STRING, in_char);
                        n = n + 3'd1;
                        if (vlen_next != '1)
                            vlen_next = vlen_next + LENGTH_BITS'(1);
                    end
                end
                M_OPER: begin
                    if (is_punct(in_char)) begin
                        cand_next = cand_upd(cand_next, vlen_next, in_char);
                        recs[n[IDX_W-1:0]] = val_rec(KIND_OPER, in_char);
                        n = n + 3'd1;
                        if (vlen_next != '1)
                            vlen_next = vlen_next + LENGTH_BITS'(1);
                        line_next = line_adv(line_next, in_char);
                        col_next  = col_adv(col_next, in_char);
                    end
                    recs[n[IDX_W-1:0]] = end_rec(KIND_OPER, line_next, col_next, vlen_next);
                    n = n + 3'd1;
                    mode_next = M_IDLE;
                    go_idle   = !is_punct(in_char);
                end
                default: begin
                    mode_next = M_IDLE;
                    go_idle   = 1'b1;
                end
            endcase

            // Start of a new token, or skip between tokens
            if (go_idle) begin
                if (is_space(in_char)) begin
                    line_next = line_adv(line_next, in_char);
                    col_next  = col_adv(col_next, in_char);
                end else if (in_char == CH_QMARK) begin
                    mode_next = M_QMARK;
                    col_next  = col_adv(col_next, in_char);
                end else if (in_char == CH_QUOTE) begin
                    mode_next = M_STRING;
                    vlen_next = '0;
                    cand_next = '1;
                    col_next  = col_adv(col_next, in_char);
                end else begin
                    vlen_next = '0;
                    cand_next = cand_upd('1, '0, in_char);
                    vlen_next = LENGTH_BITS'(1);
                    line_next = line_adv(line_next, in_char);
                    col_next  = col_adv(col_next, in_char);
                    if (is_alpha(in_char)) begin
                        mode_next = M_WORD;
                        recs[n[IDX_W-1:0]] = val_rec(KIND_IDENT, in_char);
                        n = n + 3'd1;
                    end else if (is_digit(in_char)) begin
                        mode_next = M_NUMBER;
                        recs[n[IDX_W-1:0]] = val_rec(KIND_NUMBER, in_char);
                        n = n + 3'd1;
                    end else if (is_punct(in_char)) begin
                        mode_next = M_OPER;
                        recs[n[IDX_W-1:0]] = val_rec(KIND_OPER, in_char);
                        n = n + 3'd1;
                    end else begin
                        // Unknown byte: consume it as a one-byte token
                        mode_next = M_IDLE;
                        recs[n[IDX_W-1:0]] = val_rec(KIND_UNKNOWN, in_char);
                        n = n + 3'd1;
                        recs[n[IDX_W-1:0]] = end_rec(KIND_UNKNOWN, line_next, col_next,
                                                     vlen_next);
                        n = n + 3'd1;
                    end
                end
            end
        end

        // End of source: flush the open token, add end of file, restart
        if (end_of_source) begin
            if (mode_next == M_WORD) begin
                ek = word_kind(cand_next, vlen_next);
                recs[n[IDX_W-1:0]] = end_rec(ek, line_next, col_next, vlen_next);
                n = n + 3'd1;
            end else if (mode_next == M_NUMBER) begin
                recs[n[IDX_W-1:0]] = end_rec(KIND_NUMBER, line_next, col_next, vlen_next);
                n = n + 3'd1;
            end else if (mode_next == M_STRING) begin
                recs[n[IDX_W-1:0]] = end_rec(KIND_STRING, line_next, col_next, vlen_next);
                n = n + 3'd1;
            end else if (mode_next == M_OPER) begin
                recs[n[IDX_W-1:0]] = end_rec(KIND_OPER, line_next, col_next, vlen_next);
                n = n + 3'd1;
            end
            recs[n[IDX_W-1:0]] = end_rec(KIND_EOF, line_next, col_next, '0);
            n = n + 3'd1;
            mode_next  = M_IDLE;
            line_next  = LINE_BITS'(1);
            col_next   = COLUMN_BITS'(1);
            vlen_next  = '0;
            cand_next  = '1;
            slash_next = 1'b0;
        end
    end

    // Push the bundle when the word caused any result
    assign qwr.push          = accept && (n != 3'd0);
    assign qwr.data.recs     = recs;
    assign qwr.data.last_idx = IDX_W'(n - 3'd1);

    // Scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            line_reg  <= LINE_BITS'(1);
            col_reg   <= COLUMN_BITS'(1);
            vlen_reg  <= '0;
            cand_reg  <= '1;
            slash_reg <= 1'b0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            vlen_reg  <= vlen_next;
            cand_reg  <= cand_next;
            slash_reg <= slash_next;
        end
    end

endmodule

### hdl/stt_queue.sv
// Short bundle queue between the scanner and the output serializer.
module stt_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  stt_pkg::qwr_t qwr,
    input  logic          pop,
    output logic          full,
    output stt_pkg::qrd_t qrd
);
    import stt_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    bundle_t            mem [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_pop;

    assign full      = (cnt_reg == CNT_W'(QDEPTH));
    assign qrd.empty = (cnt_reg == '0);
    assign qrd.head  = mem[rd_ptr_reg];
    assign do_pop    = pop && !qrd.empty;

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = qwr.push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (qwr.push && !do_pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (!qwr.push && do_pop)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the bundle
    always_ff @(posedge aclk) begin
        if (qwr.push)
            mem[wr_ptr_reg] <= qwr.data;
    end

endmodule

### hdl/stt_back.sv
// Output serializer: sends one result word per cycle from the current bundle while m_tready is high.
module stt_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  stt_pkg::qrd_t qrd,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   m_tdata,
    output logic [3:0]    m_tuser,
    output logic          m_tlast
);
    import stt_pkg::*;

    bundle_t           bundle_reg, bundle_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              valid_reg, valid_next;
    logic              at_last;
    logic              load;
    rec_t              cur;

    assign at_last = (idx_reg == bundle_reg.last_idx);
    assign load    = !valid_reg || (m_tready && at_last);
    assign pop     = load;

    // Load the next bundle or step through the current one
    always_comb begin
        bundle_next = bundle_reg;
        idx_next    = idx_reg;
        valid_next  = valid_reg;
        if (load) begin
            bundle_next = qrd.head;
            idx_next    = '0;
            valid_next  = !qrd.empty;
        end else if (m_tready) begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        bundle_reg <= bundle_next;
    end

    // Drive the result word
    assign cur      = bundle_reg.recs[idx_reg];
    assign m_tvalid = valid_reg;
    assign m_tlast  = at_last;
    assign m_tuser  = {cur.kind, cur.rtype};
    assign m_tdata  = {cur.len, cur.col, cur.line, cur.vchar};

endmodule

### hdl/source_text_tokenizer_top.sv
// Source text tokenizer: takes one byte word per cycle while s_tready is high, emits token
// value and end words. A result word passes through the bundle queue and the output
// register before it is offered on m_tvalid.
// Throughput: one input word per cycle while the 4-entry bundle queue has room; the
// output sends one result word per cycle while m_tready is high.
// Reset (aresetn low, synchronous): scanner idle at line 1, column 1, queue and output empty.
module source_text_tokenizer_top #(
    parameter int LINE_BITS   = 24,
    parameter int COLUMN_BITS = 16,
    parameter int LENGTH_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_char
    input  logic [0:0]  s_tuser,   // [0] has_char
    input  logic        s_tlast,   // end_of_source
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [7:0] value_char, [31:8] end_line,
                                   // [47:32] end_column, [63:48] token_length
    output logic [3:0]  m_tuser,   // [0] record_type, [3:1] token_kind
    output logic        m_tlast    // last_result
);
    import stt_pkg::*;

    qwr_t qwr;
    qrd_t qrd;
    logic q_full;
    logic q_pop;

    stt_front #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .in_char       (s_tdata),
        .has_char      (s_tuser[0]),
        .end_of_source (s_tlast),
        .q_full        (q_full),
        .qwr           (qwr)
    );

    stt_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .qwr     (qwr),
        .pop     (q_pop),
        .full    (q_full),
        .qrd     (qrd)
    );

    stt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .qrd      (qrd),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
